FILE: hdl/byte_stack_engine_unit_defines.svh
// Assertion helpers shared by the stack engine RTL.
// All checks are sampled on the rising edge of clk and are muted while rst is high.
`ifndef BYTE_STACK_ENGINE_UNIT_DEFINES_SVH
`define BYTE_STACK_ENGINE_UNIT_DEFINES_SVH

// Same-cycle implication
`define BSE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define BSE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/bse_pkg.sv
package bse_pkg;

  localparam int DEPTH_DEFAULT = 64;
  localparam int CAP_RESET     = 64;

  localparam int MODE_W = 3;
  localparam int DATA_W = 8;
  localparam int CNT_W  = 7;
  localparam int POS_W  = 8;

  localparam logic [POS_W-1:0] POS_NONE = '1;  // -1: no match

  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH   = 3'd0,
    MODE_POP    = 3'd1,
    MODE_POPN   = 3'd2,
    MODE_SEARCH = 3'd3,
    MODE_INVERT = 3'd4
  } mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_POP_WAIT,
    ST_SRCH_RD,
    ST_SRCH_CMP,
    ST_INV_RD,
    ST_INV_WLO,
    ST_INV_WHI
  } state_t;

endpackage

FILE: hdl/bse_ram.sv
module bse_ram #(
  parameter int DEPTH = bse_pkg::DEPTH_DEFAULT,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [AW-1:0]             waddr,
  input  logic [bse_pkg::DATA_W-1:0] wdata,
  input  logic                      re,
  input  logic [AW-1:0]             raddr_a,
  input  logic [AW-1:0]             raddr_b,
  output logic [bse_pkg::DATA_W-1:0] rdata_a,
  output logic [bse_pkg::DATA_W-1:0] rdata_b
);
  import bse_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data holds while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

FILE: hdl/byte_stack_engine_unit.sv
// Done is registered: push, pop several and unused modes fire their result on accept; pop fires after its RAM read.
// Search: entries examined from the top, each with one read and then one compare on the RAM.
// Invert: per swapped pair, one dual read, then two writes on the single write port.
// One command at a time; busy is high while a multi-cycle command runs. No output stall.
// Synchronous active-high reset: empty stack, capacity = min(64, depth). RAM not cleared.
`include "byte_stack_engine_unit_defines.svh"

module byte_stack_engine_unit #(
  parameter int STACK_DEPTH = bse_pkg::DEPTH_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic [bse_pkg::MODE_W-1:0]       mode,
  input  logic [bse_pkg::DATA_W-1:0]       data_in,
  input  logic [bse_pkg::CNT_W-1:0]        pop_count,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [bse_pkg::CNT_W-1:0]        cfg_data,
  output logic                             done,
  output logic                             success,
  output logic [bse_pkg::DATA_W-1:0]       data_out,
  output logic [bse_pkg::CNT_W-1:0]        removed_count,
  output logic signed [bse_pkg::POS_W-1:0] found_position,
  output logic                             is_empty,
  output logic                             is_full
);
  import bse_pkg::*;

  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CAP_RST = (CAP_RESET > STACK_DEPTH) ? STACK_DEPTH : CAP_RESET;

  state_t            state, state_next;
  logic [CW-1:0]     count, count_next;
  logic [CW-1:0]     eff_cap;
  logic [AW-1:0]     ptr;      // search cursor / invert low index
  logic [AW-1:0]     hi;       // invert high index
  logic [CW-1:0]     pos;      // 1-based depth from top
  logic [DATA_W-1:0] key;

  logic              accept;
  logic              full;
  logic              inv_more;
  logic [31:0]       popn_w;
  logic [31:0]       cfg_wide;

  logic              mem_we, mem_re;
  logic [AW-1:0]     mem_waddr, mem_ra, mem_rb;
  logic [DATA_W-1:0] mem_wdata, mem_qa, mem_qb;

  logic              res_fire;
  logic              res_success;
  logic [DATA_W-1:0] res_data;
  logic [CNT_W-1:0]  res_removed;
  logic [POS_W-1:0]  res_found;

  bse_ram #(.DEPTH(STACK_DEPTH)) u_ram (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .re      (mem_re),
    .raddr_a (mem_ra),
    .raddr_b (mem_rb),
    .rdata_a (mem_qa),
    .rdata_b (mem_qb)
  );

  assign busy      = (state != ST_IDLE);
  assign cfg_ready = ~busy;
  assign accept    = start && !busy;
  assign full      = (count >= eff_cap);
  assign inv_more  = (32'(hi) > (32'(ptr) + 32'd2));
  assign popn_w    = (32'(pop_count) < 32'(count)) ? 32'(pop_count) : 32'(count);
  assign cfg_wide  = 32'(cfg_data);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          unique case (mode_t'(mode))
            MODE_POP:    state_next = (count != '0) ? ST_POP_WAIT : ST_IDLE;
            MODE_SEARCH: state_next = (count != '0) ? ST_SRCH_RD : ST_IDLE;
            MODE_INVERT: state_next = (32'(count) >= 32'd2) ? ST_INV_RD : ST_IDLE;
            default:     state_next = ST_IDLE;
          endcase
        end
      end
      ST_POP_WAIT: state_next = ST_IDLE;
      ST_SRCH_RD:  state_next = ST_SRCH_CMP;
      ST_SRCH_CMP: begin
        state_next = ((mem_qa == key) || (ptr == '0)) ? ST_IDLE : ST_SRCH_RD;
      end
      ST_INV_RD:   state_next = ST_INV_WLO;
      ST_INV_WLO:  state_next = ST_INV_WHI;
      ST_INV_WHI:  state_next = inv_more ? ST_INV_RD : ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  // RAM controls and result values
  always_comb begin
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_waddr   = ptr;
    mem_wdata   = mem_qb;
    mem_ra      = ptr;
    mem_rb      = hi;
    res_fire    = 1'b0;
    res_success = 1'b0;
    res_data    = '0;
    res_removed = '0;
    res_found   = '0;
    count_next  = count;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          unique case (mode_t'(mode))
            MODE_PUSH: begin
              res_fire = 1'b1;
              if (!full) begin
                mem_we      = 1'b1;
                mem_waddr   = AW'(count);
                mem_wdata   = data_in;
                count_next  = count + CW'(1);
                res_success = 1'b1;
              end
            end
            MODE_POP: begin
              if (count == '0) begin
                res_fire = 1'b1;
              end else begin
                mem_re = 1'b1;
                mem_ra = AW'(count - CW'(1));
              end
            end
            MODE_POPN: begin
              res_fire    = 1'b1;
              res_removed = CNT_W'(popn_w);
              res_success = (popn_w != 32'd0);
              count_next  = count - CW'(popn_w);
            end
            MODE_SEARCH: begin
              if (count == '0) begin
                res_fire  = 1'b1;
                res_found = POS_NONE;
              end
            end
            MODE_INVERT: begin
              res_fire = (32'(count) < 32'd2);
            end
            default: res_fire = 1'b1;
          endcase
        end
      end
      ST_POP_WAIT: begin
        res_fire    = 1'b1;
        res_success = 1'b1;
        res_data    = mem_qa;
        count_next  = count - CW'(1);
      end
      ST_SRCH_RD: begin
        mem_re = 1'b1;
      end
      ST_SRCH_CMP: begin
        if (mem_qa == key) begin
          res_fire  = 1'b1;
          res_found = POS_W'(pos);
        end else if (ptr == '0) begin
          res_fire  = 1'b1;
          res_found = POS_NONE;
        end
      end
      ST_INV_RD: begin
        mem_re = 1'b1;
      end
      ST_INV_WLO: begin
        mem_we    = 1'b1;
        mem_waddr = ptr;
        mem_wdata = mem_qb;
      end
      ST_INV_WHI: begin
        mem_we    = 1'b1;
        mem_waddr = hi;
        mem_wdata = mem_qa;
        res_fire  = !inv_more;
      end
      default: ;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      count   <= '0;
      eff_cap <= CW'(CAP_RST);
      done    <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      done  <= res_fire;
      if (cfg_valid && cfg_ready) begin
        eff_cap <= (cfg_wide > 32'(STACK_DEPTH)) ? CW'(STACK_DEPTH) : CW'(cfg_wide);
      end
    end
  end

  // walk registers and result transaction payload
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && accept) begin
      key <= data_in;
      pos <= CW'(1);
      hi  <= AW'(count - CW'(1));
      ptr <= (mode_t'(mode) == MODE_SEARCH) ? AW'(count - CW'(1)) : '0;
    end else if (state == ST_SRCH_CMP) begin
      ptr <= ptr - AW'(1);
      pos <= pos + CW'(1);
    end else if (state == ST_INV_WHI) begin
      ptr <= ptr + AW'(1);
      hi  <= hi - AW'(1);
    end
    if (res_fire) begin
      success        <= res_success;
      data_out       <= res_data;
      removed_count  <= res_removed;
      found_position <= res_found;
      is_empty       <= (count_next == '0);
      is_full        <= (count_next >= eff_cap);
    end
  end

  `BSE_ASSERT_IMP(a_done_idle, done, state == ST_IDLE, "result strobe while busy")
  `BSE_ASSERT_IMP(a_empty_flag, done, is_empty == (count == '0), "empty flag off count")
  `BSE_ASSERT_IMP(a_inv_order, state == ST_INV_RD, ptr < hi, "invert indices crossed")
  `BSE_ASSERT_NXT(a_accept_next, accept, done || busy, "accepted command dropped")
  `BSE_ASSERT_IMP(a_write_range, mem_we, 32'(mem_waddr) < STACK_DEPTH, "RAM write out of range")

endmodule
